// ===== rtl/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the calibrated pose classifier.
// ----------------------------------------------------------------------------
package cpc_pkg;

  typedef enum logic [3:0] {
    PH_PRE   = 4'd0,
    PH_INIT  = 4'd1,
    PH_S_ANN = 4'd2,
    PH_S_1   = 4'd3,
    PH_S_2   = 4'd4,
    PH_S_3   = 4'd5,
    PH_D_ANN = 4'd6,
    PH_D_1   = 4'd7,
    PH_D_2   = 4'd8,
    PH_D_3   = 4'd9,
    PH_H_ANN = 4'd10,
    PH_H_1   = 4'd11,
    PH_H_2   = 4'd12,
    PH_H_3   = 4'd13,
    PH_DONE  = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    POSE_NONE     = 2'd0,
    POSE_STRAIGHT = 2'd1,
    POSE_DOWN     = 2'd2,
    POSE_HORIZ    = 2'd3
  } pose_e;

  localparam int unsigned NumPoses = 3;
  localparam int unsigned NumAxes  = 3;

  localparam logic [6:0] LED_OFF      = 7'h00;
  localparam logic [6:0] LED_TICK0    = 7'h40;
  localparam logic [6:0] LED_TICK1    = 7'h20;
  localparam logic [6:0] LED_TICK2    = 7'h10;
  localparam logic [6:0] LED_CAPTURE  = 7'h70;
  localparam logic [6:0] LED_STRAIGHT = 7'h40;
  localparam logic [6:0] LED_BENT     = 7'h10;

  localparam logic [7:0] STATUS_CLEAR = 8'h00;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] led_pattern;
    pose_e      pose_code;
    logic       calibrating;
  } cpc_result_t;

  // Pose under calibration: 0 straight, 1 down, 2 horizontal.
  function automatic logic [1:0] cal_pose_idx(phase_e p);
    logic [1:0] idx;
    case (p)
      PH_S_ANN, PH_S_1, PH_S_2, PH_S_3: idx = 2'd0;
      PH_D_ANN, PH_D_1, PH_D_2, PH_D_3: idx = 2'd1;
      PH_H_ANN, PH_H_1, PH_H_2, PH_H_3: idx = 2'd2;
      default:                          idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/cpc_if.sv =====
// ----------------------------------------------------------------------------
// cpc_if
// Valid/ready channels of the calibrated pose classifier.
// ----------------------------------------------------------------------------
interface cpc_in_if #(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] axis_a;
  logic [SAMPLE_BITS-1:0] axis_b;
  logic [SAMPLE_BITS-1:0] axis_c;
  logic [4:0]             finger_pins;

  modport source (output valid, axis_a, axis_b, axis_c, finger_pins, input ready);
  modport sink   (input valid, axis_a, axis_b, axis_c, finger_pins, output ready);
endinterface

interface cpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] led_pattern;
  logic [1:0] pose_code;
  logic       calibrating;

  modport source (output valid, status_byte, led_pattern, pose_code, calibrating,
                  input ready);
  modport sink   (input valid, status_byte, led_pattern, pose_code, calibrating,
                  output ready);
endinterface

// ===== rtl/cpc_dist.sv =====
// ----------------------------------------------------------------------------
// cpc_dist
// Squared distance of one sample to the three pose references and pick of
// the nearest pose; ties favor straight, then down.
// ----------------------------------------------------------------------------
module cpc_dist
  import cpc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic [SAMPLE_BITS-1:0] sample_i [NumAxes],
  input  logic [SAMPLE_BITS-1:0] refs_i   [NumPoses][NumAxes],
  output pose_e                  nearest_o
);

  localparam int unsigned SqBits  = 2 * SAMPLE_BITS;
  localparam int unsigned SumBits = SqBits + 2;

  logic [SAMPLE_BITS-1:0] diff   [NumPoses][NumAxes];
  logic [SqBits-1:0]      sq     [NumPoses][NumAxes];
  logic [SumBits-1:0]     sum_sq [NumPoses];

  always_comb begin
    for (int p = 0; p < NumPoses; p++) begin
      for (int k = 0; k < NumAxes; k++) begin
        diff[p][k] = (sample_i[k] >= refs_i[p][k]) ? sample_i[k] - refs_i[p][k]
                                                   : refs_i[p][k] - sample_i[k];
        sq[p][k]   = SqBits'(diff[p][k]) * SqBits'(diff[p][k]);
      end
      sum_sq[p] = SumBits'(sq[p][0]) + SumBits'(sq[p][1]) + SumBits'(sq[p][2]);
    end
  end

  always_comb begin
    if (sum_sq[0] <= sum_sq[1] && sum_sq[0] <= sum_sq[2]) begin
      nearest_o = POSE_STRAIGHT;
    end else if (sum_sq[1] <= sum_sq[2]) begin
      nearest_o = POSE_DOWN;
    end else begin
      nearest_o = POSE_HORIZ;
    end
  end

endmodule

// ===== rtl/cpc_seq.sv =====
// ----------------------------------------------------------------------------
// cpc_seq
// Calibration sequencer, pose reference store and status/LED/pose registers.
// The registers update once per item and hold the item's result.
// ----------------------------------------------------------------------------
module cpc_seq
  import cpc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned HOLD_TICKS  = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [SAMPLE_BITS-1:0] sample_i [NumAxes],
  input  logic [4:0]             pins_i,
  input  pose_e                  nearest_i,
  output logic [SAMPLE_BITS-1:0] refs_o   [NumPoses][NumAxes],
  output cpc_result_t            result_o
);

  localparam int unsigned TickBits = $clog2(HOLD_TICKS + 1);

  phase_e              phase_q, phase_d;
  logic [TickBits-1:0] tick_q, tick_d;
  logic [7:0]          status_q, status_d;
  logic [6:0]          led_q, led_d;
  pose_e               pose_q, pose_d;
  logic                run_q, run_d;
  logic                cap_en;
  logic [1:0]          cap_idx;
  logic                skip_act;

  logic [SAMPLE_BITS-1:0] refs_q [NumPoses][NumAxes];

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    status_d = status_q;
    led_d    = led_q;
    pose_d   = pose_q;
    run_d    = run_q;
    cap_en   = 1'b0;
    skip_act = 1'b0;
    cap_idx  = cal_pose_idx(phase_q);
    if (step_i) begin
      if (phase_q == PH_DONE) begin
        if (!run_q) begin
          run_d = 1'b1;
        end else begin
          pose_d   = nearest_i;
          led_d    = (nearest_i == POSE_STRAIGHT) ? LED_STRAIGHT : LED_BENT;
          status_d = {status_q[7:6], nearest_i != POSE_STRAIGHT, ~pins_i};
        end
      end else begin
        case (phase_q)
          PH_INIT: begin
            phase_d = PH_S_ANN;
          end
          PH_S_ANN, PH_D_ANN, PH_H_ANN: begin
            phase_d = phase_e'(phase_q + 4'd1);
            led_d   = LED_OFF;
            tick_d  = '0;
          end
          PH_S_1, PH_S_2, PH_S_3, PH_D_1, PH_D_2, PH_D_3,
          PH_H_1, PH_H_2, PH_H_3: begin
            if (tick_q >= TickBits'(HOLD_TICKS)) begin
              phase_d = phase_e'(phase_q + 4'd1);
              led_d   = LED_OFF;
              tick_d  = '0;
            end
          end
          default: begin
            phase_d  = PH_INIT;
            skip_act = 1'b1;
          end
        endcase
        cap_idx = cal_pose_idx(phase_d);
        if (!skip_act) begin
          if (phase_d == PH_DONE) begin
            tick_d   = '0;
            status_d = STATUS_CLEAR;
          end else if (phase_d inside {PH_S_ANN, PH_D_ANN, PH_H_ANN}) begin
            tick_d   = '0;
            status_d = {cap_idx + 2'd1, 6'd0};
          end else begin
            case (tick_d)
              TickBits'(0): led_d = LED_TICK0;
              TickBits'(1): led_d = LED_TICK1;
              TickBits'(2): led_d = LED_TICK2;
              TickBits'(3): begin
                led_d  = LED_CAPTURE;
                cap_en = 1'b1;
              end
              default: ;
            endcase
            tick_d = tick_d + TickBits'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PRE;
      tick_q   <= '0;
      status_q <= STATUS_CLEAR;
      led_q    <= LED_OFF;
      pose_q   <= POSE_NONE;
      run_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      status_q <= status_d;
      led_q    <= led_d;
      pose_q   <= pose_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      for (int k = 0; k < NumAxes; k++) begin
        refs_q[cap_idx][k] <= sample_i[k];
      end
    end
  end

  assign refs_o = refs_q;

  assign result_o.status_byte = status_q;
  assign result_o.led_pattern = led_q;
  assign result_o.pose_code   = pose_q;
  assign result_o.calibrating = (phase_q != PH_DONE);

endmodule

// ===== rtl/calibrated_pose_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// calibrated_pose_classifier_unit
// Calibration run followed by nearest-reference pose classification of
// three-axis samples, with finger pin status.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           handshake
//  in_i     in   axis_a, axis_b, axis_c, finger_pins               valid/ready
//  out_o    out  status_byte, led_pattern, pose_code, calibrating  valid/ready
//
//  One item per cycle while out_o is not stalled: an accepted item is held in
//  the input register, then the sequencer and distance logic update the result
//  registers. A stalled output holds the result; the input register still
//  takes one item. Reset restarts the calibration run; pose references are
//  undefined until captured during calibration.
// ----------------------------------------------------------------------------
module calibrated_pose_classifier_unit
  import cpc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned HOLD_TICKS  = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpc_in_if.sink    in_i,
  cpc_out_if.source out_o
);

  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q [NumAxes];
  logic [4:0]             pins_q;
  logic                   out_valid_q, out_valid_d;
  logic                   advance;
  pose_e                  nearest;
  cpc_result_t            result;
  logic [SAMPLE_BITS-1:0] refs [NumPoses][NumAxes];

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sample_q[0] <= in_i.axis_a;
      sample_q[1] <= in_i.axis_b;
      sample_q[2] <= in_i.axis_c;
      pins_q      <= in_i.finger_pins;
    end
  end

  cpc_dist #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dist (
    .sample_i (sample_q),
    .refs_i   (refs),
    .nearest_o(nearest)
  );

  cpc_seq #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .HOLD_TICKS (HOLD_TICKS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (sample_q),
    .pins_i   (pins_q),
    .nearest_i(nearest),
    .refs_o   (refs),
    .result_o (result)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.status_byte = result.status_byte;
  assign out_o.led_pattern = result.led_pattern;
  assign out_o.pose_code   = result.pose_code;
  assign out_o.calibrating = result.calibrating;

endmodule
